// File: hdl/dma4_pkg.sv
// ----------------------------------------------------------------------------
// dma4_pkg
// shared types, constants and register codes of the four channel dma block
// ----------------------------------------------------------------------------
package dma4_pkg;

   localparam int NumChannelsDefault = 4;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_DESC  = 2'd3
   } cmd_type;

   localparam logic [4:0] REG_STATUS   = 5'h00;
   localparam logic [4:0] REG_DCR_OCR  = 5'h02;
   localparam logic [4:0] REG_SCR_CCR  = 5'h03;
   localparam logic [4:0] REG_MTC      = 5'h05;
   localparam logic [4:0] REG_MAR_HI   = 5'h06;
   localparam logic [4:0] REG_MAR_LO   = 5'h07;
   localparam logic [4:0] REG_DAR_HI   = 5'h0a;
   localparam logic [4:0] REG_DAR_LO   = 5'h0b;
   localparam logic [4:0] REG_BTC      = 5'h0d;
   localparam logic [4:0] REG_BAR_HI   = 5'h0e;
   localparam logic [4:0] REG_BAR_LO   = 5'h0f;
   localparam logic [4:0] REG_NIV      = 5'h12;
   localparam logic [4:0] REG_EIV      = 5'h13;
   localparam logic [4:0] REG_MFC      = 5'h14;
   localparam logic [4:0] REG_CPR      = 5'h16;
   localparam logic [4:0] REG_DFC      = 5'h18;
   localparam logic [4:0] REG_BFC      = 5'h1c;
   localparam logic [4:0] REG_GCR      = 5'h1f;

   localparam logic [1:0] WAIT_NONE  = 2'd0;
   localparam logic [1:0] WAIT_START = 2'd1;
   localparam logic [1:0] WAIT_CHAIN = 2'd2;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;
   localparam logic [1:0] SIZE_LONG = 2'd2;

   localparam logic [15:0] UNMAPPED_READ = 16'h00ff;
   localparam logic [31:0] DESC_BYTES    = 32'd6;

   // one channel's context as it sits in the context memory
   typedef struct packed {
      logic [7:0]  status;
      logic [7:0]  dcr;
      logic [7:0]  ocr;
      logic [7:0]  scr;
      logic [7:0]  ccr;
      logic [15:0] mem_count;
      logic [15:0] base_count;
      logic [31:0] mem_addr;
      logic [31:0] dev_addr;
      logic [31:0] base_addr;
      logic [55:0] vec;
      logic [15:0] saved_count;
      logic        active;
      logic        halted;
      logic [1:0]  wait_desc;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      status: 8'h00, dcr: 8'h00, ocr: 8'h00, scr: 8'h00, ccr: 8'h00,
      mem_count: 16'h0, base_count: 16'h0, mem_addr: 32'h0, dev_addr: 32'h0,
      base_addr: 32'h0, vec: 56'h0f0f, saved_count: 16'h0, active: 1'b0,
      halted: 1'b0, wait_desc: WAIT_NONE};

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  channel;
      logic [4:0]  reg_index;
      logic [15:0] write_data;
      logic [1:0]  byte_lanes;
      logic        device_ready;
      logic [15:0] desc_addr_high;
      logic [15:0] desc_addr_low;
      logic [15:0] desc_count;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        xfer_valid;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [1:0]  xfer_size;
      logic        via_device_port;
      logic        write_suppressed;
      logic        desc_fetch_valid;
      logic [31:0] desc_fetch_addr;
      logic        channel_done;
      logic        done_irq_enable;
      logic        cpu_halt;
   } rsp_type;

   // halt line effect of one request
   typedef struct packed {
      logic set;
      logic clr;
   } halt_type;

endpackage

// File: hdl/dma4_ctx_mem.sv
// ----------------------------------------------------------------------------
// dma4_ctx_mem
// per channel context memory, one write and one registered read port, with
// valid bits standing in for the reset contents
// ----------------------------------------------------------------------------
module dma4_ctx_mem #(
   parameter int NUM_CHANNELS = dma4_pkg::NumChannelsDefault,
   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output dma4_pkg::ctx_type rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  dma4_pkg::ctx_type wr_data
);
   import dma4_pkg::*;

   ctx_type                 mem [NUM_CHANNELS];
   ctx_type                 rd_q_ff;
   logic [NUM_CHANNELS-1:0] vld_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // a read of the entry being written returns the new data
         rd_q_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr] | (wr_en && wr_addr == rd_addr);
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : CTX_RESET;

endmodule

// File: hdl/dma4_exec.sv
// ----------------------------------------------------------------------------
// dma4_exec
// applies one request to a channel context: register access, control
// commands, transfer ticks and descriptor replies
// ----------------------------------------------------------------------------
module dma4_exec (
   input  dma4_pkg::req_type  req,
   input  dma4_pkg::ctx_type  ctx,
   input  logic               port,
   input  logic               chan_ok,
   output dma4_pkg::ctx_type  ctx_new,
   output logic               ctx_write,
   output dma4_pkg::rsp_type  rsp,
   output dma4_pkg::halt_type halt
);
   import dma4_pkg::*;

   ctx_type     c;
   logic [7:0]  d_lo;
   logic [7:0]  d_hi;
   logic        to_mem;
   logic [1:0]  sz;
   logic [31:0] step;
   logic [15:0] cnt_dec;
   logic        burst;

   always_comb begin
      c         = ctx;
      rsp       = '0;
      halt      = '0;
      ctx_write = 1'b0;
      d_lo      = req.write_data[7:0];
      d_hi      = req.write_data[15:8];
      to_mem    = ctx.ocr[7];
      sz        = SIZE_BYTE;
      step      = 32'd1;
      cnt_dec   = 16'd0;
      burst     = (ctx.dcr[7:6] == 2'b00);
      if (!chan_ok) begin
         if (req.cmd == CMD_READ) begin
            rsp.read_data = UNMAPPED_READ;
         end
      end else begin
         case (req.cmd)
            CMD_READ: begin
               case (req.reg_index)
                  REG_STATUS:  rsp.read_data = {ctx.status, 8'h00};
                  REG_DCR_OCR: rsp.read_data = {ctx.dcr, ctx.ocr};
                  REG_SCR_CCR: rsp.read_data = {ctx.scr, ctx.ccr};
                  REG_MTC:     rsp.read_data = ctx.mem_count;
                  REG_MAR_HI:  rsp.read_data = ctx.mem_addr[31:16];
                  REG_MAR_LO:  rsp.read_data = ctx.mem_addr[15:0];
                  REG_DAR_HI:  rsp.read_data = ctx.dev_addr[31:16];
                  REG_DAR_LO:  rsp.read_data = ctx.dev_addr[15:0];
                  REG_BTC:     rsp.read_data = ctx.base_count;
                  REG_BAR_HI:  rsp.read_data = ctx.base_addr[31:16];
                  REG_BAR_LO:  rsp.read_data = ctx.base_addr[15:0];
                  REG_NIV:     rsp.read_data = {8'h00, ctx.vec[7:0]};
                  REG_EIV:     rsp.read_data = {8'h00, ctx.vec[15:8]};
                  REG_MFC:     rsp.read_data = {8'h00, ctx.vec[23:16]};
                  REG_CPR:     rsp.read_data = {8'h00, ctx.vec[31:24]};
                  REG_DFC:     rsp.read_data = {8'h00, ctx.vec[39:32]};
                  REG_BFC:     rsp.read_data = {8'h00, ctx.vec[47:40]};
                  REG_GCR:     rsp.read_data = {8'h00, ctx.vec[55:48]};
                  default:     rsp.read_data = UNMAPPED_READ;
               endcase
            end
            CMD_WRITE: begin
               ctx_write = 1'b1;
               case (req.reg_index)
                  REG_DCR_OCR: begin
                     if (req.byte_lanes[1]) c.dcr = d_hi;
                     if (req.byte_lanes[0]) c.ocr = d_lo;
                  end
                  REG_SCR_CCR: begin
                     if (req.byte_lanes[1]) c.scr = d_hi;
                     if (req.byte_lanes[0]) begin
                        c.ccr = d_lo;
                        if (d_lo[7]) begin
                           c.active = 1'b1;
                           c.halted = 1'b0;
                           c.status = (c.status & 8'h0f) | 8'h08;
                           if (c.base_count != 16'd0) begin
                              c.base_count = c.base_count - 16'd1;
                              c.wait_desc  = WAIT_START;
                              rsp.desc_fetch_valid = 1'b1;
                              rsp.desc_fetch_addr  = c.base_addr;
                           end else begin
                              c.wait_desc   = WAIT_NONE;
                              c.saved_count = c.mem_count;
                           end
                           if (c.dcr[7:6] == 2'b00) halt.set = 1'b1;
                        end
                        if (d_lo[4]) begin
                           c.active    = 1'b0;
                           c.wait_desc = WAIT_NONE;
                           c.mem_count = c.saved_count;
                           c.status    = (c.status | 8'he0) & 8'hf7;
                        end
                        if (d_lo[5]) c.halted = 1'b1;
                        if (d_lo[6]) c.halted = 1'b0;
                     end
                  end
                  REG_MTC:    c.mem_count = req.write_data;
                  REG_MAR_HI: c.mem_addr[31:16] = req.write_data;
                  REG_MAR_LO: c.mem_addr[15:0] = req.write_data;
                  REG_DAR_HI: c.dev_addr[31:16] = req.write_data;
                  REG_DAR_LO: c.dev_addr[15:0] = req.write_data;
                  REG_BTC:    c.base_count = req.write_data;
                  REG_BAR_HI: c.base_addr[31:16] = req.write_data;
                  REG_BAR_LO: c.base_addr[15:0] = req.write_data;
                  REG_NIV:    c.vec[7:0] = d_lo;
                  REG_EIV:    c.vec[15:8] = d_lo;
                  REG_MFC:    c.vec[23:16] = d_lo;
                  REG_CPR:    c.vec[31:24] = d_lo;
                  REG_DFC:    c.vec[39:32] = d_lo;
                  REG_BFC:    c.vec[47:40] = d_lo;
                  REG_GCR:    c.vec[55:48] = d_lo;
                  default:    ctx_write = 1'b0;
               endcase
            end
            CMD_TICK: begin
               if (ctx.active && !ctx.halted && ctx.wait_desc == WAIT_NONE &&
                   !(to_mem && port && !req.device_ready)) begin
                  ctx_write = 1'b1;
                  if (!port) begin
                     case (ctx.ocr[5:4])
                        2'b01:   sz = SIZE_WORD;
                        2'b10:   sz = SIZE_LONG;
                        2'b11:   rsp.write_suppressed = !to_mem;
                        default: sz = SIZE_BYTE;
                     endcase
                  end
                  step = 32'd1 << sz;
                  rsp.xfer_valid      = 1'b1;
                  rsp.src_addr        = to_mem ? ctx.dev_addr : ctx.mem_addr;
                  rsp.dst_addr        = to_mem ? ctx.mem_addr : ctx.dev_addr;
                  rsp.xfer_size       = sz;
                  rsp.via_device_port = port;
                  cnt_dec = (ctx.mem_count != 16'd0) ? ctx.mem_count - 16'd1 : 16'd0;
                  c.mem_count = cnt_dec;
                  case (ctx.scr[1:0])
                     2'b01:   c.dev_addr = ctx.dev_addr + step;
                     2'b10:   c.dev_addr = ctx.dev_addr - step;
                     default: c.dev_addr = ctx.dev_addr;
                  endcase
                  case (ctx.scr[3:2])
                     2'b01:   c.mem_addr = ctx.mem_addr + step;
                     2'b10:   c.mem_addr = ctx.mem_addr - step;
                     default: c.mem_addr = ctx.mem_addr;
                  endcase
                  if (cnt_dec == 16'd0) begin
                     if (ctx.base_count != 16'd0) begin
                        c.base_count = ctx.base_count - 16'd1;
                        c.base_addr  = ctx.base_addr + DESC_BYTES;
                        c.wait_desc  = WAIT_CHAIN;
                        rsp.desc_fetch_valid = 1'b1;
                        rsp.desc_fetch_addr  = ctx.base_addr + DESC_BYTES;
                     end else begin
                        c.active    = 1'b0;
                        c.wait_desc = WAIT_NONE;
                        c.mem_count = ctx.saved_count;
                        c.status    = (ctx.status | 8'he0) & 8'hf7;
                        halt.clr    = burst;
                        rsp.channel_done    = 1'b1;
                        rsp.done_irq_enable = ctx.ccr[3];
                     end
                  end
               end
            end
            default: begin
               if (ctx.wait_desc != WAIT_NONE) begin
                  ctx_write   = 1'b1;
                  c.mem_addr  = {req.desc_addr_high, req.desc_addr_low};
                  c.mem_count = req.desc_count;
                  if (ctx.wait_desc == WAIT_START) c.saved_count = req.desc_count;
                  c.wait_desc = WAIT_NONE;
               end
            end
         endcase
      end
      ctx_new = c;
   end

endmodule

// File: hdl/four_channel_dma_controller_top.sv
// ----------------------------------------------------------------------------
// four_channel_dma_controller_top
// Four channel dma controller with descriptor chaining. Each request (a
// register read or write, a transfer tick or a descriptor reply) yields one
// response: the channel context memory is read first, then the request is
// applied and the response and the new context are registered for writeback.
// A new request is taken every cycle unless a held response is stalled by
// rsp_stall; a request to the channel written back in the same cycle gets
// the fresh context forwarded. The context memory has a read port and a
// write port of its own.
// ----------------------------------------------------------------------------
module four_channel_dma_controller_top #(
   parameter int NUM_CHANNELS = dma4_pkg::NumChannelsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_device_port_mask,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [1:0]  req_channel,
   input  logic [4:0]  req_reg_index,
   input  logic [15:0] req_write_data,
   input  logic [1:0]  req_byte_lanes,
   input  logic        req_device_ready,
   input  logic [15:0] req_desc_addr_high,
   input  logic [15:0] req_desc_addr_low,
   input  logic [15:0] req_desc_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic        rsp_xfer_valid,
   output logic [31:0] rsp_src_addr,
   output logic [31:0] rsp_dst_addr,
   output logic [1:0]  rsp_xfer_size,
   output logic        rsp_via_device_port,
   output logic        rsp_write_suppressed,
   output logic        rsp_desc_fetch_valid,
   output logic [31:0] rsp_desc_fetch_addr,
   output logic        rsp_channel_done,
   output logic        rsp_done_irq_enable,
   output logic        rsp_cpu_halt
);
   import dma4_pkg::*;

   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic [3:0] port_mask_ff;
   logic       s1_vld_ff;
   req_type    s1_req_ff;
   logic       ex_ok;
   logic       ex_fwd;
   ctx_type    mem_rd;
   ctx_type    ex_ctx;
   ctx_type    ex_new;
   logic       ex_wr;
   rsp_type    ex_rsp;
   halt_type   ex_halt;
   logic       halt_ff;
   logic       halt_in;
   logic       wb_vld_ff;
   logic [AW-1:0] wb_addr_ff;
   ctx_type    wb_ctx_ff;
   logic       out_vld_ff;
   rsp_type    out_ff;
   rsp_type    out_in;
   logic       adv;
   logic       req_take;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] ex_addr;
   req_type    req_in;

   assign csr_ready = 1'b1;
   assign adv       = !out_vld_ff || !rsp_stall;
   assign req_stall = !adv;
   assign req_take  = req_valid && adv;
   assign rd_addr   = req_channel[AW-1:0];
   assign ex_addr   = s1_req_ff.channel[AW-1:0];
   assign ex_ok     = ({1'b0, s1_req_ff.channel} < 3'(NUM_CHANNELS));
   assign ex_fwd    = wb_vld_ff && wb_addr_ff == ex_addr;
   assign ex_ctx    = ex_fwd ? wb_ctx_ff : mem_rd;

   assign req_in = '{cmd: req_cmd, channel: req_channel, reg_index: req_reg_index,
      write_data: req_write_data, byte_lanes: req_byte_lanes,
      device_ready: req_device_ready, desc_addr_high: req_desc_addr_high,
      desc_addr_low: req_desc_addr_low, desc_count: req_desc_count};

   dma4_ctx_mem #(.NUM_CHANNELS(NUM_CHANNELS)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (mem_rd),
      .wr_en   (wb_vld_ff),
      .wr_addr (wb_addr_ff),
      .wr_data (wb_ctx_ff)
   );

   dma4_exec u_exec (
      .req       (s1_req_ff),
      .ctx       (ex_ctx),
      .port      (port_mask_ff[s1_req_ff.channel]),
      .chan_ok   (ex_ok),
      .ctx_new   (ex_new),
      .ctx_write (ex_wr),
      .rsp       (ex_rsp),
      .halt      (ex_halt)
   );

   always_comb begin
      halt_in = halt_ff;
      if (ex_halt.set) halt_in = 1'b1;
      if (ex_halt.clr) halt_in = 1'b0;
   end

   always_comb begin
      out_in          = ex_rsp;
      out_in.cpu_halt = halt_in;
   end

   // writeback stays valid while stalled so the held request keeps its forward
   always_ff @(posedge clock) begin
      if (reset) begin
         port_mask_ff <= '0;
         s1_vld_ff    <= 1'b0;
         wb_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         halt_ff      <= 1'b0;
      end else begin
         if (csr_valid) port_mask_ff <= csr_device_port_mask;
         if (adv) begin
            s1_vld_ff  <= req_take;
            out_vld_ff <= s1_vld_ff;
            wb_vld_ff  <= s1_vld_ff && ex_wr && ex_ok;
            if (s1_vld_ff) begin
               halt_ff <= halt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_req_ff <= req_in;
      if (adv && s1_vld_ff) begin
         out_ff     <= out_in;
         wb_addr_ff <= ex_addr;
         wb_ctx_ff  <= ex_new;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_read_data        = out_ff.read_data;
   assign rsp_xfer_valid       = out_ff.xfer_valid;
   assign rsp_src_addr         = out_ff.src_addr;
   assign rsp_dst_addr         = out_ff.dst_addr;
   assign rsp_xfer_size        = out_ff.xfer_size;
   assign rsp_via_device_port  = out_ff.via_device_port;
   assign rsp_write_suppressed = out_ff.write_suppressed;
   assign rsp_desc_fetch_valid = out_ff.desc_fetch_valid;
   assign rsp_desc_fetch_addr  = out_ff.desc_fetch_addr;
   assign rsp_channel_done     = out_ff.channel_done;
   assign rsp_done_irq_enable  = out_ff.done_irq_enable;
   assign rsp_cpu_halt         = out_ff.cpu_halt;

`ifndef NO_ASSERTIONS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && rsp_stall |=> out_vld_ff && $stable(out_ff))
      else $error("response changed while stalled");
   a_wb_once: assert property (@(posedge clock) disable iff (reset)
      $rose(wb_vld_ff) |-> $past(s1_vld_ff) && $past(adv))
      else $error("writeback without a request");
   a_done_no_fetch: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> !(out_ff.channel_done && out_ff.desc_fetch_valid))
      else $error("done and descriptor fetch together");
`endif

endmodule

// File: verif/four_channel_dma_controller_checker.sv
// ----------------------------------------------------------------------------
// four_channel_dma_controller_checker
// Watches the request, response and csr channels of the dma controller. Keeps
// its own copy of every channel's context and works out the response each
// accepted request must produce. Compares each accepted response field by
// field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module four_channel_dma_controller_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [3:0]        csr_device_port_mask,
   input  logic              req_valid,
   input  logic              req_stall,
   input  dma4_pkg::req_type req,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  dma4_pkg::rsp_type rsp,
   output int                fail_count,
   output int                pending_count
);
   import dma4_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic [3:0]  port_mask;
   logic [7:0]  status_q [4];
   logic [7:0]  dcr_q [4];
   logic [7:0]  ocr_q [4];
   logic [7:0]  scr_q [4];
   logic [7:0]  ccr_q [4];
   logic [15:0] mem_count_q [4];
   logic [15:0] base_count_q [4];
   logic [31:0] mem_addr_q [4];
   logic [31:0] dev_addr_q [4];
   logic [31:0] base_addr_q [4];
   logic [7:0]  vec_q [4][7];
   logic [15:0] saved_count_q [4];
   logic        active_q [4];
   logic        halted_q [4];
   logic [1:0]  wait_q [4];
   logic        halt_line_q;
   rsp_type     expected_rsps [$];

   assign pending_count = expected_rsps.size();

   task automatic clear_context();
      port_mask = '0;
      halt_line_q = 1'b0;
      for (int c = 0; c < 4; c++) begin
         status_q[c] = '0; dcr_q[c] = '0; ocr_q[c] = '0; scr_q[c] = '0;
         ccr_q[c] = '0; mem_count_q[c] = '0; base_count_q[c] = '0;
         mem_addr_q[c] = '0; dev_addr_q[c] = '0; base_addr_q[c] = '0;
         for (int k = 0; k < 7; k++) vec_q[c][k] = '0;
         vec_q[c][0] = 8'h0f;
         vec_q[c][1] = 8'h0f;
         saved_count_q[c] = '0; active_q[c] = 1'b0; halted_q[c] = 1'b0;
         wait_q[c] = WAIT_NONE;
      end
   endtask

   task automatic end_transfer(input int c);
      active_q[c] = 1'b0;
      wait_q[c] = WAIT_NONE;
      mem_count_q[c] = saved_count_q[c];
      status_q[c] = (status_q[c] | 8'he0) & ~8'h08;
   endtask

   task automatic start_channel(input int c, inout rsp_type o);
      active_q[c] = 1'b1;
      halted_q[c] = 1'b0;
      status_q[c] = (status_q[c] & 8'h0f) | 8'h08;
      if (base_count_q[c] != 0) begin
         base_count_q[c]--;
         wait_q[c] = WAIT_START;
         o.desc_fetch_valid = 1'b1;
         o.desc_fetch_addr = base_addr_q[c];
      end else begin
         wait_q[c] = WAIT_NONE;
         saved_count_q[c] = mem_count_q[c];
      end
      if (dcr_q[c][7:6] == 2'b00) halt_line_q = 1'b1;
   endtask

   function automatic int vec_slot(input logic [4:0] r);
      case (r)
         REG_NIV: return 0;
         REG_EIV: return 1;
         REG_MFC: return 2;
         REG_CPR: return 3;
         REG_DFC: return 4;
         REG_BFC: return 5;
         REG_GCR: return 6;
         default: return -1;
      endcase
   endfunction

   task automatic read_register(input int c, input logic [4:0] r, output logic [15:0] v);
      int slot;
      slot = vec_slot(r);
      case (r)
         REG_STATUS:  v = {status_q[c], 8'h00};
         REG_DCR_OCR: v = {dcr_q[c], ocr_q[c]};
         REG_SCR_CCR: v = {scr_q[c], ccr_q[c]};
         REG_MTC:     v = mem_count_q[c];
         REG_MAR_HI:  v = mem_addr_q[c][31:16];
         REG_MAR_LO:  v = mem_addr_q[c][15:0];
         REG_DAR_HI:  v = dev_addr_q[c][31:16];
         REG_DAR_LO:  v = dev_addr_q[c][15:0];
         REG_BTC:     v = base_count_q[c];
         REG_BAR_HI:  v = base_addr_q[c][31:16];
         REG_BAR_LO:  v = base_addr_q[c][15:0];
         default:     v = (slot >= 0) ? {8'h00, vec_q[c][slot]} : UNMAPPED_READ;
      endcase
   endtask

   task automatic write_register(input req_type q, inout rsp_type o);
      int c;
      int slot;
      logic [15:0] d;
      c = q.channel;
      d = q.write_data;
      slot = vec_slot(q.reg_index);
      case (q.reg_index)
         REG_DCR_OCR: begin
            if (q.byte_lanes[1]) dcr_q[c] = d[15:8];
            if (q.byte_lanes[0]) ocr_q[c] = d[7:0];
         end
         REG_SCR_CCR: begin
            if (q.byte_lanes[1]) scr_q[c] = d[15:8];
            if (q.byte_lanes[0]) begin
               ccr_q[c] = d[7:0];
               if (d[7]) start_channel(c, o);
               if (d[4]) end_transfer(c);
               if (d[5]) halted_q[c] = 1'b1;
               if (d[6]) halted_q[c] = 1'b0;
            end
         end
         REG_MTC:    mem_count_q[c] = d;
         REG_MAR_HI: mem_addr_q[c][31:16] = d;
         REG_MAR_LO: mem_addr_q[c][15:0] = d;
         REG_DAR_HI: dev_addr_q[c][31:16] = d;
         REG_DAR_LO: dev_addr_q[c][15:0] = d;
         REG_BTC:    base_count_q[c] = d;
         REG_BAR_HI: base_addr_q[c][31:16] = d;
         REG_BAR_LO: base_addr_q[c][15:0] = d;
         default:    if (slot >= 0) vec_q[c][slot] = d[7:0];
      endcase
   endtask

   task automatic transfer_tick(input int c, input logic ready, inout rsp_type o);
      logic        port;
      logic        to_mem;
      logic [1:0]  size;
      logic [31:0] step;
      port = port_mask[c];
      to_mem = ocr_q[c][7];
      size = SIZE_BYTE;
      if (!active_q[c] || halted_q[c] || wait_q[c] != WAIT_NONE) return;
      if (to_mem && port && !ready) return;
      if (!port) begin
         case (ocr_q[c][5:4])
            2'b01: size = SIZE_WORD;
            2'b10: size = SIZE_LONG;
            2'b11: if (!to_mem) o.write_suppressed = 1'b1;
            default: ;
         endcase
      end
      o.xfer_valid = 1'b1;
      o.src_addr = to_mem ? dev_addr_q[c] : mem_addr_q[c];
      o.dst_addr = to_mem ? mem_addr_q[c] : dev_addr_q[c];
      o.xfer_size = size;
      o.via_device_port = port;
      step = 32'd1 << size;
      if (mem_count_q[c] != 0) mem_count_q[c]--;
      if (scr_q[c][1:0] == 2'b01) dev_addr_q[c] += step;
      else if (scr_q[c][1:0] == 2'b10) dev_addr_q[c] -= step;
      if (scr_q[c][3:2] == 2'b01) mem_addr_q[c] += step;
      else if (scr_q[c][3:2] == 2'b10) mem_addr_q[c] -= step;
      if (mem_count_q[c] == 0) begin
         if (base_count_q[c] != 0) begin
            base_count_q[c]--;
            base_addr_q[c] += DESC_BYTES;
            wait_q[c] = WAIT_CHAIN;
            o.desc_fetch_valid = 1'b1;
            o.desc_fetch_addr = base_addr_q[c];
            return;
         end
         end_transfer(c);
         if (dcr_q[c][7:6] == 2'b00) halt_line_q = 1'b0;
         o.channel_done = 1'b1;
         o.done_irq_enable = ccr_q[c][3];
      end
   endtask

   task automatic predict_response(input req_type q, output rsp_type o);
      int c;
      c = q.channel;
      o = '0;
      case (cmd_type'(q.cmd))
         CMD_READ:  read_register(c, q.reg_index, o.read_data);
         CMD_WRITE: write_register(q, o);
         CMD_TICK:  transfer_tick(c, q.device_ready, o);
         default: begin
            if (wait_q[c] != WAIT_NONE) begin
               mem_addr_q[c] = {q.desc_addr_high, q.desc_addr_low};
               mem_count_q[c] = q.desc_count;
               if (wait_q[c] == WAIT_START) saved_count_q[c] = q.desc_count;
               wait_q[c] = WAIT_NONE;
            end
         end
      endcase
      o.cpu_halt = halt_line_q;
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type o;
      rsp_type e;
      if (reset) begin
         clear_context();
         expected_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) port_mask = csr_device_port_mask;
         if (req_valid && !req_stall) begin
            predict_response(req, o);
            expected_rsps.push_back(o);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no request pending");
               fail_count++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("read_data", 32'(e.read_data), 32'(rsp.read_data));
               check_field("xfer_valid", 32'(e.xfer_valid), 32'(rsp.xfer_valid));
               check_field("src_addr", e.src_addr, rsp.src_addr);
               check_field("dst_addr", e.dst_addr, rsp.dst_addr);
               check_field("xfer_size", 32'(e.xfer_size), 32'(rsp.xfer_size));
               check_field("via_device_port", 32'(e.via_device_port),
                           32'(rsp.via_device_port));
               check_field("write_suppressed", 32'(e.write_suppressed),
                           32'(rsp.write_suppressed));
               check_field("desc_fetch_valid", 32'(e.desc_fetch_valid),
                           32'(rsp.desc_fetch_valid));
               check_field("desc_fetch_addr", e.desc_fetch_addr, rsp.desc_fetch_addr);
               check_field("channel_done", 32'(e.channel_done), 32'(rsp.channel_done));
               check_field("done_irq_enable", 32'(e.done_irq_enable),
                           32'(rsp.done_irq_enable));
               check_field("cpu_halt", 32'(e.cpu_halt), 32'(rsp.cpu_halt));
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// File: verif/four_channel_dma_controller_top_test.sv
// ----------------------------------------------------------------------------
// four_channel_dma_controller_top_test
// Drives register accesses, transfer ticks and descriptor replies into the
// dma controller with random idle gaps and response stalls, across several
// device port masks. A checker beside the block predicts every response.
// ----------------------------------------------------------------------------
module four_channel_dma_controller_top_test;
   import dma4_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CCR_START    = 8'h80;
   localparam logic [7:0] CCR_CONTINUE = 8'h40;
   localparam logic [7:0] CCR_HALT     = 8'h20;
   localparam logic [7:0] CCR_ABORT    = 8'h10;
   localparam logic [7:0] CCR_IRQ_EN   = 8'h08;
   localparam logic [1:0] LANES_BOTH   = 2'b11;
   localparam logic [1:0] LANES_UPPER  = 2'b10;
   localparam logic [1:0] LANES_LOWER  = 2'b01;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_device_port_mask = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [1:0]  req_channel = '0;
   logic [4:0]  req_reg_index = '0;
   logic [15:0] req_write_data = '0;
   logic [1:0]  req_byte_lanes = '0;
   logic        req_device_ready = 1'b0;
   logic [15:0] req_desc_addr_high = '0;
   logic [15:0] req_desc_addr_low = '0;
   logic [15:0] req_desc_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_read_data;
   logic        rsp_xfer_valid;
   logic [31:0] rsp_src_addr;
   logic [31:0] rsp_dst_addr;
   logic [1:0]  rsp_xfer_size;
   logic        rsp_via_device_port;
   logic        rsp_write_suppressed;
   logic        rsp_desc_fetch_valid;
   logic [31:0] rsp_desc_fetch_addr;
   logic        rsp_channel_done;
   logic        rsp_done_irq_enable;
   logic        rsp_cpu_halt;

   int      fail_count;
   int      pending_count;
   int      requests_sent = 0;
   logic    idling_on = 1'b1;
   int      stall_left = 0;
   req_type req_bus;
   rsp_type rsp_bus;

   always #2 clock = ~clock;

   four_channel_dma_controller_top uut (.*);

   assign req_bus = '{cmd: req_cmd, channel: req_channel, reg_index: req_reg_index,
                      write_data: req_write_data, byte_lanes: req_byte_lanes,
                      device_ready: req_device_ready, desc_addr_high: req_desc_addr_high,
                      desc_addr_low: req_desc_addr_low, desc_count: req_desc_count};
   assign rsp_bus = '{read_data: rsp_read_data, xfer_valid: rsp_xfer_valid,
                      src_addr: rsp_src_addr, dst_addr: rsp_dst_addr,
                      xfer_size: rsp_xfer_size, via_device_port: rsp_via_device_port,
                      write_suppressed: rsp_write_suppressed,
                      desc_fetch_valid: rsp_desc_fetch_valid,
                      desc_fetch_addr: rsp_desc_fetch_addr,
                      channel_done: rsp_channel_done, done_irq_enable: rsp_done_irq_enable,
                      cpu_halt: rsp_cpu_halt};

   four_channel_dma_controller_checker checker_i (
      .clock, .reset, .csr_valid, .csr_ready, .csr_device_port_mask,
      .req_valid, .req_stall, .req(req_bus), .rsp_valid, .rsp_stall, .rsp(rsp_bus),
      .fail_count, .pending_count);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= gap_length();
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(input cmd_type cmd, input int ch, input logic [4:0] idx,
                       input logic [15:0] data, input logic [1:0] lanes, input logic ready,
                       input logic [15:0] dh, input logic [15:0] dl, input logic [15:0] dc);
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_channel <= 2'(ch);
      req_reg_index <= idx;
      req_write_data <= data;
      req_byte_lanes <= lanes;
      req_device_ready <= ready;
      req_desc_addr_high <= dh;
      req_desc_addr_low <= dl;
      req_desc_count <= dc;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      requests_sent++;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic reg_read(input int ch, input logic [4:0] idx);
      send(CMD_READ, ch, idx, 16'($urandom), 2'($urandom), 1'($urandom),
           16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic reg_write(input int ch, input logic [4:0] idx, input logic [15:0] d,
                            input logic [1:0] lanes);
      send(CMD_WRITE, ch, idx, d, lanes, 1'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom));
   endtask

   task automatic xfer_tick(input int ch, input logic ready);
      send(CMD_TICK, ch, 5'($urandom), 16'($urandom), 2'($urandom), ready,
           16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic desc_reply(input int ch, input logic [15:0] dc);
      send(CMD_DESC, ch, 5'($urandom), 16'($urandom), 2'($urandom), 1'($urandom),
           16'($urandom), 16'($urandom), dc);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_port_mask(input logic [3:0] m);
      drain();
      csr_valid <= 1'b1;
      csr_device_port_mask <= m;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_channel(input int ch);
      logic [4:0] idx_list [8];
      idx_list = '{REG_MAR_HI, REG_MAR_LO, REG_DAR_HI, REG_DAR_LO, REG_BAR_HI, REG_BAR_LO,
                   REG_NIV, REG_GCR};
      foreach (idx_list[k]) reg_write(ch, idx_list[k], 16'($urandom), 2'($urandom));
      reg_write(ch, REG_MTC, 16'($urandom_range(1, 4)), 2'($urandom));
      reg_write(ch, REG_BTC, ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 2)) : 16'h0,
                2'($urandom));
      reg_write(ch, REG_DCR_OCR, 16'($urandom), LANES_BOTH);
      reg_write(ch, REG_SCR_CCR, {8'($urandom), 8'h00}, LANES_UPPER);
      reg_write(ch, REG_SCR_CCR, {8'($urandom), CCR_START | (CCR_IRQ_EN & 8'($urandom))},
                LANES_LOWER);
   endtask

   task automatic noise_request();
      int ch;
      int pick;
      ch = $urandom_range(0, 3);
      pick = $urandom_range(0, 9);
      if (pick < 3) reg_read(ch, 5'($urandom));
      else if (pick < 5) xfer_tick(ch, 1'($urandom));
      else if (pick < 6) desc_reply(ch, 16'($urandom));
      else if (pick < 7) reg_write(ch, REG_SCR_CCR, 16'($urandom), 2'($urandom));
      else reg_write(ch, 5'($urandom), 16'($urandom), 2'($urandom));
   endtask

   task automatic run_sequence();
      int ch;
      int steps;
      ch = $urandom_range(0, 3);
      program_channel(ch);
      steps = $urandom_range(4, 14);
      for (int s = 0; s < steps; s++) begin
         case ($urandom_range(0, 15))
            0, 1:    desc_reply(ch, 16'($urandom_range(1, 3)));
            2:       reg_read(ch, 5'($urandom_range(0, 31)));
            3:       noise_request();
            4:       reg_write(ch, REG_SCR_CCR, {8'h00, CCR_HALT}, LANES_LOWER);
            5:       reg_write(ch, REG_SCR_CCR, {8'h00, CCR_CONTINUE}, LANES_LOWER);
            6:       if ($urandom_range(0, 3) == 0)
                        reg_write(ch, REG_SCR_CCR, {8'h00, CCR_ABORT}, LANES_LOWER);
            default: xfer_tick(ch, ($urandom_range(0, 4) != 0));
         endcase
      end
   endtask

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic [3:0] masks [5];
      masks = '{4'h0, 4'hf, 4'h5, 4'ha, 4'h0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, register accesses, lanes, start, descriptor fetch, halt, abort
      idling_on = 1'b0;
      reg_read(0, REG_NIV);
      reg_read(3, REG_EIV);
      reg_read(1, 5'h01);
      reg_write(2, REG_STATUS, 16'hffff, LANES_BOTH);
      reg_write(2, REG_DCR_OCR, 16'hffff, LANES_UPPER);
      reg_write(2, REG_DCR_OCR, 16'h0000, LANES_LOWER);
      reg_write(2, REG_SCR_CCR, 16'h0505, 2'b00);
      reg_read(2, REG_DCR_OCR);
      reg_write(0, REG_MAR_HI, 16'hffff, LANES_BOTH);
      reg_write(0, REG_MAR_LO, 16'hfffe, LANES_LOWER);
      reg_write(0, REG_DAR_LO, 16'h0000, LANES_UPPER);
      reg_write(0, REG_BTC, 16'h0001, LANES_BOTH);
      reg_write(0, REG_BAR_LO, 16'h1000, LANES_BOTH);
      reg_write(0, REG_DCR_OCR, 16'h0020, LANES_BOTH);
      reg_write(0, REG_SCR_CCR, {8'h05, CCR_START | CCR_IRQ_EN}, LANES_BOTH);
      xfer_tick(0, 1'b1);
      desc_reply(0, 16'h0001);
      reg_write(0, REG_SCR_CCR, {8'h05, CCR_HALT}, LANES_LOWER);
      xfer_tick(0, 1'b1);
      reg_write(0, REG_SCR_CCR, {8'h05, CCR_CONTINUE}, LANES_LOWER);
      xfer_tick(0, 1'b1);
      reg_read(0, REG_STATUS);
      reg_write(1, REG_SCR_CCR, {8'h00, CCR_START | CCR_ABORT}, LANES_BOTH);
      desc_reply(1, 16'hffff);
      reg_read(1, REG_MTC);
      idling_on = 1'b1;

      foreach (masks[m]) begin
         set_port_mask(m == 4 ? 4'($urandom) : masks[m]);
         idling_on = (m != 2);
         while (requests_sent < 25 + 120 * (m + 1)) begin
            if ($urandom_range(0, 4) == 0) noise_request();
            else run_sequence();
         end
      end
      drain();

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
